>>> sv/ikc_pkg.sv
// ----------------------------------------------------------------------------
// ikc_pkg
// Shared constants, key and command codes, and controller/datapath structs
// for the infix keypad calculator.
// ----------------------------------------------------------------------------
`default_nettype none

package ikc_pkg;

   localparam int WORD_WIDTH_DEF = 32;
   localparam int OUT_WIDTH      = 32;
   localparam int OP_WIDTH       = 3;
   localparam int DIGIT_WIDTH    = 4;

   // key kinds
   localparam logic [OP_WIDTH-1:0] KEY_DIGIT  = 3'd0;
   localparam logic [OP_WIDTH-1:0] KEY_PLUS   = 3'd1;
   localparam logic [OP_WIDTH-1:0] KEY_MINUS  = 3'd2;
   localparam logic [OP_WIDTH-1:0] KEY_TIMES  = 3'd3;
   localparam logic [OP_WIDTH-1:0] KEY_DIVIDE = 3'd4;
   localparam logic [OP_WIDTH-1:0] KEY_EQUALS = 3'd5;

   // pending operation on the product term
   localparam logic [1:0] TERM_NONE = 2'd0;
   localparam logic [1:0] TERM_MUL  = 2'd1;
   localparam logic [1:0] TERM_DIV  = 2'd2;

   // datapath commands
   localparam logic [3:0] CMD_NOP         = 4'd0;
   localparam logic [3:0] CMD_DIGIT       = 4'd1;
   localparam logic [3:0] CMD_FACTOR_LOAD = 4'd2;
   localparam logic [3:0] CMD_FACTOR_ERR  = 4'd3;
   localparam logic [3:0] CMD_MUL_START   = 4'd4;
   localparam logic [3:0] CMD_MUL_STEP    = 4'd5;
   localparam logic [3:0] CMD_MUL_DONE    = 4'd6;
   localparam logic [3:0] CMD_DIV_START   = 4'd7;
   localparam logic [3:0] CMD_DIV_STEP    = 4'd8;
   localparam logic [3:0] CMD_DIV_DONE    = 4'd9;
   localparam logic [3:0] CMD_SET_TERM    = 4'd10;
   localparam logic [3:0] CMD_CLOSE_TERM  = 4'd11;
   localparam logic [3:0] CMD_FINISH      = 4'd12;

   typedef struct packed {
      logic [3:0] code;
      logic [1:0] term;
      logic       sub;
   } dp_cmd_type;

   typedef struct packed {
      logic [1:0] term;
      logic       cur_zero;
      logic       out_free;
   } dp_status_type;

endpackage

`default_nettype wire

>>> sv/ikc_req_if.sv
// ----------------------------------------------------------------------------
// ikc_req_if
// Key channel: valid/ready handshake carrying key kind and digit value.
// ----------------------------------------------------------------------------
`default_nettype none

interface ikc_req_if;
   import ikc_pkg::*;

   logic                   valid;
   logic                   ready;
   logic [OP_WIDTH-1:0]    op;
   logic [DIGIT_WIDTH-1:0] digit;

   modport source (output valid, output op, output digit, input ready);
   modport sink   (input valid, input op, input digit, output ready);
endinterface

`default_nettype wire

>>> sv/ikc_rsp_if.sv
// ----------------------------------------------------------------------------
// ikc_rsp_if
// Result channel: valid/ready handshake carrying value and error flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface ikc_rsp_if;
   import ikc_pkg::*;

   logic                        valid;
   logic                        ready;
   logic signed [OUT_WIDTH-1:0] value;
   logic                        div_error;

   modport source (output valid, output value, output div_error, input ready);
   modport sink   (input valid, input value, input div_error, output ready);
endinterface

`default_nettype wire

>>> sv/ikc_datapath.sv
// ----------------------------------------------------------------------------
// ikc_datapath
// Expression registers, shared shift-add multiplier / restoring divider,
// and the result output register.
// ----------------------------------------------------------------------------
`default_nettype none

module ikc_datapath
   import ikc_pkg::*;
#(
   parameter int WORD_WIDTH = WORD_WIDTH_DEF
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire dp_cmd_type             cmd,
   input  wire logic [DIGIT_WIDTH-1:0] digit,
   output dp_status_type               status,
   ikc_rsp_if.source                   rsp_ch
);

   localparam int W = WORD_WIDTH;

   logic [W-1:0] sum_ff, sum_in;
   logic         sub_ff, sub_in;
   logic [W-1:0] prod_ff, prod_in;
   logic [1:0]   term_ff, term_in;
   logic [W-1:0] cur_ff, cur_in;
   logic         err_ff, err_in;
   logic [W-1:0] opa_ff, opa_in;
   logic [W-1:0] opb_ff, opb_in;
   logic [W-1:0] acc_ff, acc_in;
   logic         neg_ff, neg_in;
   logic         ovalid_ff, ovalid_in;
   logic signed [OUT_WIDTH-1:0] oval_ff, oval_in;
   logic         oerr_ff, oerr_in;

   logic [W-1:0] prod_mag, cur_mag;
   logic [W:0]   rem_shift, trial;
   logic [W-1:0] total;
   logic signed [W-1:0] total_s;
   logic         out_free;

   assign prod_mag  = prod_ff[W-1] ? (W'(0) - prod_ff) : prod_ff;
   assign cur_mag   = cur_ff[W-1] ? (W'(0) - cur_ff) : cur_ff;
   assign rem_shift = {acc_ff, opa_ff[W-1]};
   assign trial     = rem_shift - {1'b0, opb_ff};
   assign total     = sub_ff ? (sum_ff - prod_ff) : (sum_ff + prod_ff);
   assign total_s   = signed'(total);
   assign out_free  = !ovalid_ff || rsp_ch.ready;

   always_comb begin
      sum_in    = sum_ff;
      sub_in    = sub_ff;
      prod_in   = prod_ff;
      term_in   = term_ff;
      cur_in    = cur_ff;
      err_in    = err_ff;
      opa_in    = opa_ff;
      opb_in    = opb_ff;
      acc_in    = acc_ff;
      neg_in    = neg_ff;
      oval_in   = oval_ff;
      oerr_in   = oerr_ff;
      ovalid_in = ovalid_ff && !rsp_ch.ready;
      unique case (cmd.code)
         CMD_DIGIT: begin
            cur_in = (cur_ff << 3) + (cur_ff << 1) + W'(digit);
         end
         CMD_FACTOR_LOAD: begin
            prod_in = cur_ff;
            cur_in  = '0;
         end
         CMD_FACTOR_ERR: begin
            err_in = 1'b1;
            cur_in = '0;
         end
         CMD_MUL_START: begin
            acc_in = '0;
            opa_in = prod_ff;
            opb_in = cur_ff;
            cur_in = '0;
         end
         CMD_MUL_STEP: begin
            if (opb_ff[0]) begin
               acc_in = acc_ff + opa_ff;
            end
            opa_in = opa_ff << 1;
            opb_in = opb_ff >> 1;
         end
         CMD_MUL_DONE: begin
            prod_in = acc_ff;
         end
         CMD_DIV_START: begin
            acc_in = '0;
            opa_in = prod_mag;
            opb_in = cur_mag;
            neg_in = prod_ff[W-1] ^ cur_ff[W-1];
            cur_in = '0;
         end
         CMD_DIV_STEP: begin
            // restoring step: quotient bits shift in at the bottom of opa
            if (!trial[W]) begin
               acc_in = trial[W-1:0];
               opa_in = {opa_ff[W-2:0], 1'b1};
            end else begin
               acc_in = rem_shift[W-1:0];
               opa_in = {opa_ff[W-2:0], 1'b0};
            end
         end
         CMD_DIV_DONE: begin
            prod_in = neg_ff ? (W'(0) - opa_ff) : opa_ff;
         end
         CMD_SET_TERM: begin
            term_in = cmd.term;
         end
         CMD_CLOSE_TERM: begin
            sum_in  = total;
            prod_in = '0;
            term_in = TERM_NONE;
            sub_in  = cmd.sub;
         end
         CMD_FINISH: begin
            ovalid_in = 1'b1;
            oerr_in   = err_ff;
            oval_in   = err_ff ? -32'sd1 : OUT_WIDTH'(total_s);
            sum_in    = '0;
            sub_in    = 1'b0;
            prod_in   = '0;
            term_in   = TERM_NONE;
            cur_in    = '0;
            err_in    = 1'b0;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff    <= '0;
         sub_ff    <= 1'b0;
         prod_ff   <= '0;
         term_ff   <= TERM_NONE;
         cur_ff    <= '0;
         err_ff    <= 1'b0;
         ovalid_ff <= 1'b0;
      end else begin
         sum_ff    <= sum_in;
         sub_ff    <= sub_in;
         prod_ff   <= prod_in;
         term_ff   <= term_in;
         cur_ff    <= cur_in;
         err_ff    <= err_in;
         ovalid_ff <= ovalid_in;
      end
   end

   always_ff @(posedge clock) begin
      opa_ff  <= opa_in;
      opb_ff  <= opb_in;
      acc_ff  <= acc_in;
      neg_ff  <= neg_in;
      oval_ff <= oval_in;
      oerr_ff <= oerr_in;
   end

   assign status.term     = term_ff;
   assign status.cur_zero = (cur_ff == '0);
   assign status.out_free = out_free;

   assign rsp_ch.valid     = ovalid_ff;
   assign rsp_ch.value     = oval_ff;
   assign rsp_ch.div_error = oerr_ff;

endmodule

`default_nettype wire

>>> sv/ikc_controller.sv
// ----------------------------------------------------------------------------
// ikc_controller
// Key sequencing: closes factors and terms, runs the iterative
// multiply/divide one step per word bit, issues datapath commands.
// ----------------------------------------------------------------------------
`default_nettype none

module ikc_controller
   import ikc_pkg::*;
#(
   parameter int WORD_WIDTH = WORD_WIDTH_DEF
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire dp_status_type status,
   output dp_cmd_type         cmd,
   ikc_req_if.sink            req_ch
);

   localparam int CNT_W = $clog2(WORD_WIDTH);
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(WORD_WIDTH - 1);

   localparam logic [2:0] S_IDLE    = 3'd0;
   localparam logic [2:0] S_MUL     = 3'd1;
   localparam logic [2:0] S_MUL_FIN = 3'd2;
   localparam logic [2:0] S_DIV     = 3'd3;
   localparam logic [2:0] S_DIV_FIN = 3'd4;
   localparam logic [2:0] S_POST    = 3'd5;

   logic [2:0]          state_ff, state_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic [OP_WIDTH-1:0] key_ff, key_in;
   logic                accept;

   assign req_ch.ready = (state_ff == S_IDLE);
   assign accept       = req_ch.valid && req_ch.ready;

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      key_in   = key_ff;
      cmd      = '{code: CMD_NOP, term: TERM_NONE, sub: 1'b0};
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               key_in = req_ch.op;
               cnt_in = '0;
               if (req_ch.op == KEY_DIGIT) begin
                  cmd.code = CMD_DIGIT;
               end else if (req_ch.op == KEY_PLUS || req_ch.op == KEY_MINUS ||
                            req_ch.op == KEY_TIMES || req_ch.op == KEY_DIVIDE ||
                            req_ch.op == KEY_EQUALS) begin
                  // close the factor that this operator ends
                  priority if (status.term == TERM_MUL) begin
                     cmd.code = CMD_MUL_START;
                     state_in = S_MUL;
                  end else if (status.term == TERM_DIV && status.cur_zero) begin
                     cmd.code = CMD_FACTOR_ERR;
                     state_in = S_POST;
                  end else if (status.term == TERM_DIV) begin
                     cmd.code = CMD_DIV_START;
                     state_in = S_DIV;
                  end else begin
                     cmd.code = CMD_FACTOR_LOAD;
                     state_in = S_POST;
                  end
               end
            end
         end
         S_MUL: begin
            cmd.code = CMD_MUL_STEP;
            cnt_in   = cnt_ff + 1'b1;
            if (cnt_ff == CNT_LAST) begin
               state_in = S_MUL_FIN;
            end
         end
         S_MUL_FIN: begin
            cmd.code = CMD_MUL_DONE;
            state_in = S_POST;
         end
         S_DIV: begin
            cmd.code = CMD_DIV_STEP;
            cnt_in   = cnt_ff + 1'b1;
            if (cnt_ff == CNT_LAST) begin
               state_in = S_DIV_FIN;
            end
         end
         S_DIV_FIN: begin
            cmd.code = CMD_DIV_DONE;
            state_in = S_POST;
         end
         S_POST: begin
            priority if (key_ff == KEY_TIMES) begin
               cmd.code = CMD_SET_TERM;
               cmd.term = TERM_MUL;
               state_in = S_IDLE;
            end else if (key_ff == KEY_DIVIDE) begin
               cmd.code = CMD_SET_TERM;
               cmd.term = TERM_DIV;
               state_in = S_IDLE;
            end else if (key_ff == KEY_EQUALS) begin
               // hold until the output register can take the transaction
               if (status.out_free) begin
                  cmd.code = CMD_FINISH;
                  state_in = S_IDLE;
               end
            end else begin
               cmd.code = CMD_CLOSE_TERM;
               cmd.sub  = (key_ff == KEY_MINUS);
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff <= key_in;
   end

endmodule

`default_nettype wire

>>> sv/infix_keypad_calculator.sv
// ----------------------------------------------------------------------------
// infix_keypad_calculator
// Keypad-driven integer calculator with multiply/divide precedence.
// ----------------------------------------------------------------------------
// Keys arrive one transaction at a time on req_ch; one result leaves on
// rsp_ch for each equals key. An operator or equals key passes through the
// post state alone when no multiply or divide is pending or when a pending
// divide meets a zero divisor, and through the multiply or divide steps and
// their finishing state first when it closes a multiply or a divide, worked by
// the shared one-bit-per-cycle shift-add/restoring arithmetic unit. Equals
// additionally waits while the previous result is still held in the output
// register. Division truncates toward zero, all arithmetic wraps at WORD_WIDTH
// bits, and any division by zero makes the result -1 with div_error set.
// ----------------------------------------------------------------------------
`default_nettype none

module infix_keypad_calculator
   import ikc_pkg::*;
#(
   parameter int WORD_WIDTH = WORD_WIDTH_DEF
) (
   input  wire logic clock,
   input  wire logic reset,
   ikc_req_if.sink   req_ch,
   ikc_rsp_if.source rsp_ch
);

   dp_cmd_type    cmd;
   dp_status_type status;

   ikc_controller #(
      .WORD_WIDTH(WORD_WIDTH)
   ) u_controller (
      .clock (clock),
      .reset (reset),
      .status(status),
      .cmd   (cmd),
      .req_ch(req_ch)
   );

   ikc_datapath #(
      .WORD_WIDTH(WORD_WIDTH)
   ) u_datapath (
      .clock (clock),
      .reset (reset),
      .cmd   (cmd),
      .digit (req_ch.digit),
      .status(status),
      .rsp_ch(rsp_ch)
   );

endmodule

`default_nettype wire

>>> test/ikc_result_check.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ikc_result_check
// Watches the key and result channels of the keypad calculator, keeps its own
// model of the expression state, and compares every result with the oldest
// value it predicted.
// ----------------------------------------------------------------------------

module ikc_result_check
   import ikc_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   ikc_req_if        req_ch,
   ikc_rsp_if        rsp_ch,
   output int        fail_count,
   output int        results_due,
   output int        results_checked,
   output int        error_results
);

   typedef struct {
      bit [31:0] value;
      bit        div_error;
   } calc_result_type;

   calc_result_type expected_results[$];
   calc_result_type oldest;

   bit [31:0]  sum_of_terms;
   bit         subtract_term;
   bit [31:0]  term_value;
   logic [1:0] pending_term_op;
   bit [31:0]  entry_value;
   bit         div_by_zero_seen;

   initial begin
      fail_count      = 0;
      results_due     = 0;
      results_checked = 0;
      error_results   = 0;
   end

   // quotient truncated toward zero; most negative over minus one wraps
   function automatic bit [31:0] divide_toward_zero(bit [31:0] dividend, bit [31:0] divisor);
      bit [31:0] mag_a;
      bit [31:0] mag_b;
      bit [31:0] quotient;
      mag_a    = dividend[31] ? -dividend : dividend;
      mag_b    = divisor[31] ? -divisor : divisor;
      quotient = mag_a / mag_b;
      return (dividend[31] ^ divisor[31]) ? -quotient : quotient;
   endfunction

   task automatic clear_calc();
      sum_of_terms     = '0;
      subtract_term    = 1'b0;
      term_value       = '0;
      pending_term_op  = TERM_NONE;
      entry_value      = '0;
      div_by_zero_seen = 1'b0;
   endtask

   task automatic apply_key(logic [2:0] op, logic [3:0] digit);
      calc_result_type outcome;
      if (op == KEY_DIGIT) begin
         entry_value = entry_value * 32'd10 + 32'(digit);
      end else if (op <= KEY_EQUALS) begin
         // finish the factor being entered (an empty entry counts as zero)
         case (pending_term_op)
            TERM_MUL: term_value = term_value * entry_value;
            TERM_DIV: begin
               if (entry_value == 0)
                  div_by_zero_seen = 1'b1;
               else
                  term_value = divide_toward_zero(term_value, entry_value);
            end
            default: term_value = entry_value;
         endcase
         entry_value = '0;
         if (op == KEY_TIMES || op == KEY_DIVIDE) begin
            pending_term_op = (op == KEY_TIMES) ? TERM_MUL : TERM_DIV;
         end else begin
            sum_of_terms    = subtract_term ? sum_of_terms - term_value
                                            : sum_of_terms + term_value;
            term_value      = '0;
            pending_term_op = TERM_NONE;
            if (op == KEY_EQUALS) begin
               outcome.value     = div_by_zero_seen ? 32'hFFFF_FFFF : sum_of_terms;
               outcome.div_error = div_by_zero_seen;
               expected_results.push_back(outcome);
               clear_calc();
            end else begin
               subtract_term = (op == KEY_MINUS);
            end
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         clear_calc();
         expected_results.delete();
      end else begin
         // results first: a key taken at this edge cannot have produced one yet
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_results.size() == 0) begin
               fail_count++;
               $display("%0t: unexpected result, nothing expected, got value %0d div_error %0b",
                        $time, rsp_ch.value, rsp_ch.div_error);
            end else begin
               oldest = expected_results.pop_front();
               results_checked++;
               if (oldest.div_error)
                  error_results++;
               if (rsp_ch.value !== oldest.value) begin
                  fail_count++;
                  $display("%0t: value mismatch, expected %0d, actual %0d",
                           $time, $signed(oldest.value), rsp_ch.value);
               end
               if (rsp_ch.div_error !== oldest.div_error) begin
                  fail_count++;
                  $display("%0t: div_error mismatch, expected %0b, actual %0b",
                           $time, oldest.div_error, rsp_ch.div_error);
               end
            end
         end
         if (req_ch.valid && req_ch.ready)
            apply_key(req_ch.op, req_ch.digit);
         results_due = expected_results.size();
      end
   end

endmodule

>>> test/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Keypad calculator testbench: sends key sequences for whole expressions,
// directed corner cases first and then random ones, across phases of sender
// and receiver idling, and reports the verdict from the result checker.
// ----------------------------------------------------------------------------

module tb;
   import ikc_pkg::*;

   // op codes with no meaning; the block must ignore them
   localparam logic [OP_WIDTH-1:0] KEY_UNUSED_LO = 3'd6;
   localparam logic [OP_WIDTH-1:0] KEY_UNUSED_HI = 3'd7;

   localparam int HOLD_OFF_CYCLES = 300;
   localparam int DRAIN_CYCLES    = 40;

   logic clock;
   logic reset;

   int sender_idle_pct;
   int receiver_stall_pct;
   bit hold_request;
   bit hold_ready;
   int keys_sent;
   int expressions_sent;

   int fail_count;
   int results_due;
   int results_checked;
   int error_results;

   ikc_req_if req_ch ();
   ikc_rsp_if rsp_ch ();

   infix_keypad_calculator dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   ikc_result_check u_check (
      .clock           (clock),
      .reset           (reset),
      .req_ch          (req_ch),
      .rsp_ch          (rsp_ch),
      .fail_count      (fail_count),
      .results_due     (results_due),
      .results_checked (results_checked),
      .error_results   (error_results)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #6_000_000;
      $display("timeout with %0d results still expected", results_due);
      $display("*** FAILED ***");
      $finish;
   end

   // long receiver hold-off, counted here so the sender keeps offering keys
   initial begin
      hold_ready = 1'b0;
      wait (hold_request);
      hold_ready = 1'b1;
      repeat (HOLD_OFF_CYCLES) @(negedge clock);
      hold_ready = 1'b0;
   end

   initial begin
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_ch.ready = !hold_ready && ($urandom_range(0, 99) >= receiver_stall_pct);
      end
   end

   task automatic send_key(logic [2:0] op, logic [3:0] digit);
      int gap;
      gap = 0;
      while ($urandom_range(0, 99) < sender_idle_pct && gap < 40)
         gap++;
      if (gap > 0) begin
         req_ch.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_ch.valid = 1'b1;
      req_ch.op    = op;
      req_ch.digit = digit;
      do
         @(posedge clock);
      while (!req_ch.ready);
      @(negedge clock);
      keys_sent++;
   endtask

   // digits 0-9 and a-f, operators + - * /, equals =, unused codes ? and !
   task automatic key_text(string text);
      byte        c;
      logic [2:0] op;
      logic [3:0] digit;
      for (int i = 0; i < text.len(); i++) begin
         c     = text[i];
         digit = $urandom_range(0, 15);
         case (c)
            "+": op = KEY_PLUS;
            "-": op = KEY_MINUS;
            "*": op = KEY_TIMES;
            "/": op = KEY_DIVIDE;
            "=": op = KEY_EQUALS;
            "?": op = KEY_UNUSED_LO;
            "!": op = KEY_UNUSED_HI;
            default: begin
               op    = KEY_DIGIT;
               digit = (c >= "a") ? 4'(c - "a" + 10) : 4'(c - "0");
            end
         endcase
         send_key(op, digit);
      end
   endtask

   function automatic string random_operand();
      int    pick;
      string text;
      text = "";
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
         text = "";  // missing number
      end else if (pick < 55) begin
         text = $sformatf("%0d", $urandom_range(0, 20));
      end else if (pick < 75) begin
         text = $sformatf("%0d", $urandom_range(0, 999));
      end else if (pick < 88) begin
         text = $sformatf("%0d", $urandom);
      end else if (pick < 94) begin
         case ($urandom_range(0, 3))
            0: text = "2147483648";
            1: text = "2147483647";
            2: text = "4294967295";
            default: text = "0";
         endcase
      end else begin
         // hex digits, so values above nine can occur
         repeat ($urandom_range(1, 3))
            text = $sformatf("%s%h", text, 4'($urandom_range(0, 15)));
      end
      return text;
   endfunction

   task automatic send_random_expression();
      string text;
      string op_chars;
      int    k;
      op_chars = "+-*/";
      if ($urandom_range(0, 15) == 0)
         text = "2147483648/4294967295";  // most negative over minus one
      else
         text = random_operand();
      repeat ($urandom_range(0, 5)) begin
         if ($urandom_range(0, 24) == 0)
            text = {text, ($urandom_range(0, 1) == 0) ? "?" : "!"};
         k    = $urandom_range(0, 3);
         text = {text, op_chars.substr(k, k), random_operand()};
      end
      key_text({text, "="});
      expressions_sent++;
   endtask

   task automatic send_until(int key_target);
      while (keys_sent < key_target)
         send_random_expression();
   endtask

   task automatic pause_for_results();
      req_ch.valid = 1'b0;
      wait (results_due == 0);
      @(negedge clock);
   endtask

   initial begin
      reset              = 1'b1;
      req_ch.valid       = 1'b0;
      req_ch.op          = KEY_DIGIT;
      req_ch.digit       = '0;
      sender_idle_pct    = 0;
      receiver_stall_pct = 0;
      hold_request       = 1'b0;
      keys_sent          = 0;
      expressions_sent   = 0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // precedence, empty equals, divide by zero, high digits with unused codes
      key_text("7+8*9-6/4=");
      key_text("=");
      key_text("9/0*3=");
      key_text("f?!e-*8=");
      expressions_sent += 4;
      pause_for_results();

      // receiver holds off while keys keep coming, filling the block
      hold_request = 1'b1;
      send_until(200);
      pause_for_results();

      sender_idle_pct = 77;
      send_until(400);
      pause_for_results();

      sender_idle_pct    = 0;
      receiver_stall_pct = 77;
      send_until(600);
      pause_for_results();

      sender_idle_pct    = 8;
      receiver_stall_pct = 8;
      send_until(800);

      req_ch.valid = 1'b0;
      wait (results_due == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d keys in %0d expressions under four idling phases",
               keys_sent, expressions_sent);
      $display("checked %0d results, %0d of them with a division by zero",
               results_checked, error_results);
      if (fail_count == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
